>>> design/obsd_pkg.sv
`timescale 1ns / 1ps

package obsd_pkg;

   localparam int unsigned KIND_W   = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned REC_BYTES = 20;
   localparam int unsigned REC_W    = 8 * REC_BYTES;
   localparam int unsigned CNT_W    = $clog2(REC_BYTES + 1);
   localparam int unsigned REQ_DATA_W = 160;
   localparam int unsigned RSP_DATA_W = 424;

   localparam logic [KIND_W-1:0] KIND_BEGIN     = 4'd0;
   localparam logic [KIND_W-1:0] KIND_BYTE      = 4'd1;
   localparam logic [KIND_W-1:0] KIND_LOCATE    = 4'd2;
   localparam logic [KIND_W-1:0] KIND_BID_COUNT = 4'd3;
   localparam logic [KIND_W-1:0] KIND_ASK_COUNT = 4'd4;
   localparam logic [KIND_W-1:0] KIND_LEVEL     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_ORD_COUNT = 4'd6;
   localparam logic [KIND_W-1:0] KIND_ORDER     = 4'd7;
   localparam logic [KIND_W-1:0] KIND_FINISH    = 4'd8;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_COUNT_OVF = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHARE_OVF = 2'd2;

   localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
   localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
   localparam int unsigned FNV_PRIME_SHIFT = 40;

   localparam logic [55:0] DOMAIN_TAG = 56'h41_45_47_49_53_42_4B;
   localparam logic [7:0]  FORMAT_VERSION = 8'h01;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

endpackage

>>> design/order_book_state_digest.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports        Payload
// req      in   req_t*       tuser: kind; tdata: record fields
// rsp      out  rsp_t*       tdata: digest and totals
//
// A record is accepted, then folded one serialized byte at a time (0 to 20 bytes)
// by the single xor-multiply hash step.
// A finish moves to the emit state and loads the result register once it is free.
// Reset (synchronous) restores the hash basis and clears all totals.
// req_tready is low while a record is folding or a finish is placing its result;
// a waiting result never blocks non-finish records.
module order_book_state_digest (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // wide_value[63:0], word_a[95:64], word_b[127:96], short_value[143:128],
   // byte_value[151:144], attributed[152], zero fill
   input  logic [obsd_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind[3:0]
   input  logic [obsd_pkg::KIND_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // digest_hash[63:0], last_sequence[127:64], symbols[159:128],
   // active_orders[223:160], bid_levels[287:224], ask_levels[351:288],
   // displayed_shares[415:352], status[417:416], zero fill
   output logic [obsd_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   obsd_pkg::state_type state_ff, state_in;

   logic [63:0] hash_ff, hash_in;
   logic [63:0] seq_ff, seq_in;
   logic [31:0] sym_ff, sym_in;
   logic [63:0] ord_ff, ord_in;
   logic [63:0] bid_ff, bid_in;
   logic [63:0] ask_ff, ask_in;
   logic [63:0] shr_ff, shr_in;
   logic [obsd_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [obsd_pkg::REC_W-1:0] buf_ff, buf_in;
   logic [obsd_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [obsd_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [63:0] f_wide;
   logic [31:0] f_wa, f_wb;
   logic [15:0] f_sv;
   logic [7:0]  f_bv;
   logic        f_at;

   logic        accept, out_free;
   logic [63:0] fold_x, fold_mul, fold_next;
   logic [63:0] add_tot, add_val;
   logic [64:0] add_sum;
   logic [63:0] add_res;
   logic        add_ovf;
   logic [obsd_pkg::STATUS_W-1:0] add_code;

   assign f_wide = req_tdata[63:0];
   assign f_wa   = req_tdata[95:64];
   assign f_wb   = req_tdata[127:96];
   assign f_sv   = req_tdata[143:128];
   assign f_bv   = req_tdata[151:144];
   assign f_at   = req_tdata[152];

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // one FNV-1a step on the top byte: prime = 2^40 + 0x1B3
   assign fold_x    = hash_ff ^ {56'd0, buf_ff[obsd_pkg::REC_W-1 -: 8]};
   assign fold_mul  = fold_x * 64'(obsd_pkg::FNV_PRIME_LO);
   assign fold_next = (fold_x << obsd_pkg::FNV_PRIME_SHIFT) + fold_mul;

   always_comb begin
      add_tot  = bid_ff;
      add_val  = {32'd0, f_wa};
      add_code = obsd_pkg::STATUS_COUNT_OVF;
      case (req_tuser)
         obsd_pkg::KIND_ASK_COUNT: begin
            add_tot = ask_ff;
         end
         obsd_pkg::KIND_LEVEL: begin
            add_tot  = shr_ff;
            add_val  = f_wide;
            add_code = obsd_pkg::STATUS_SHARE_OVF;
         end
         obsd_pkg::KIND_ORD_COUNT: begin
            add_tot = ord_ff;
            add_val = f_wide;
         end
         default: begin
         end
      endcase
      add_sum = {1'b0, add_tot} + {1'b0, add_val};
      add_ovf = add_sum[64];
      add_res = add_ovf ? '1 : add_sum[63:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         obsd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser == obsd_pkg::KIND_FINISH) begin
                  state_in = obsd_pkg::ST_EMIT;
               end else if (req_tuser <= obsd_pkg::KIND_ORDER) begin
                  state_in = obsd_pkg::ST_RUN;
               end
            end
         end
         obsd_pkg::ST_RUN: begin
            if (cnt_ff == obsd_pkg::CNT_W'(1)) begin
               state_in = obsd_pkg::ST_IDLE;
            end
         end
         obsd_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = obsd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = obsd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         obsd_pkg::ST_IDLE: req_tready = 1'b1;
         obsd_pkg::ST_RUN:  req_tready = 1'b0;
         obsd_pkg::ST_EMIT: req_tready = 1'b0;
         default:           req_tready = 1'b0;
      endcase
   end

   always_comb begin
      hash_in     = hash_ff;
      seq_in      = seq_ff;
      sym_in      = sym_ff;
      ord_in      = ord_ff;
      bid_in      = bid_ff;
      ask_in      = ask_ff;
      shr_in      = shr_ff;
      status_in   = status_ff;
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (state_ff == obsd_pkg::ST_RUN) begin
         hash_in = fold_next;
         buf_in  = buf_ff << 8;
         cnt_in  = cnt_ff - obsd_pkg::CNT_W'(1);
      end

      if (state_ff == obsd_pkg::ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, status_ff, shr_ff, ask_ff, bid_ff, ord_ff,
                         sym_ff, seq_ff, hash_ff};
      end

      if (accept) begin
         unique case (req_tuser)
            obsd_pkg::KIND_BEGIN: begin
               hash_in   = obsd_pkg::FNV_BASIS;
               seq_in    = f_wide;
               sym_in    = f_wa;
               ord_in    = '0;
               bid_in    = '0;
               ask_in    = '0;
               shr_in    = '0;
               status_in = obsd_pkg::STATUS_OK;
               buf_in    = {obsd_pkg::DOMAIN_TAG, obsd_pkg::FORMAT_VERSION, f_wide, f_wa};
               cnt_in    = obsd_pkg::CNT_W'(20);
            end
            obsd_pkg::KIND_BYTE: begin
               buf_in = {f_bv, 152'd0};
               cnt_in = obsd_pkg::CNT_W'(1);
            end
            obsd_pkg::KIND_LOCATE: begin
               buf_in = {f_sv, 144'd0};
               cnt_in = obsd_pkg::CNT_W'(2);
            end
            obsd_pkg::KIND_BID_COUNT, obsd_pkg::KIND_ASK_COUNT: begin
               buf_in = {f_wa, 128'd0};
               cnt_in = obsd_pkg::CNT_W'(4);
            end
            obsd_pkg::KIND_LEVEL: begin
               buf_in = {f_wa, f_wide, f_wb, 32'd0};
               cnt_in = obsd_pkg::CNT_W'(16);
            end
            obsd_pkg::KIND_ORD_COUNT: begin
               buf_in = {f_wide, 96'd0};
               cnt_in = obsd_pkg::CNT_W'(8);
            end
            obsd_pkg::KIND_ORDER: begin
               buf_in = {f_wide, f_sv, f_bv, f_wa, f_wb, 7'd0, f_at};
               cnt_in = obsd_pkg::CNT_W'(20);
            end
            default: begin
            end
         endcase

         if (req_tuser inside {obsd_pkg::KIND_BID_COUNT, obsd_pkg::KIND_ASK_COUNT,
                               obsd_pkg::KIND_LEVEL, obsd_pkg::KIND_ORD_COUNT}) begin
            if (add_ovf && status_ff == obsd_pkg::STATUS_OK) begin
               status_in = add_code;
            end
            case (req_tuser)
               obsd_pkg::KIND_BID_COUNT: bid_in = add_res;
               obsd_pkg::KIND_ASK_COUNT: ask_in = add_res;
               obsd_pkg::KIND_LEVEL:     shr_in = add_res;
               default:                  ord_in = add_res;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= obsd_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hash_ff      <= obsd_pkg::FNV_BASIS;
         seq_ff       <= '0;
         sym_ff       <= '0;
         ord_ff       <= '0;
         bid_ff       <= '0;
         ask_ff       <= '0;
         shr_ff       <= '0;
         status_ff    <= obsd_pkg::STATUS_OK;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hash_ff      <= hash_in;
         seq_ff       <= seq_in;
         sym_ff       <= sym_in;
         ord_ff       <= ord_in;
         bid_ff       <= bid_in;
         ask_ff       <= ask_in;
         shr_ff       <= shr_in;
         status_ff    <= status_in;
      end
      buf_ff      <= buf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_run_has_bytes: assert property (@(posedge clock) disable iff (reset)
      state_ff == obsd_pkg::ST_RUN |-> cnt_ff != '0)
      else $error("folding with no bytes left");

   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == obsd_pkg::KIND_FINISH |=> state_ff == obsd_pkg::ST_EMIT)
      else $error("finish did not reach emit");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == obsd_pkg::ST_EMIT && out_free |=> rsp_valid_ff)
      else $error("emit did not load result");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      status_ff == obsd_pkg::STATUS_OK || status_ff == obsd_pkg::STATUS_COUNT_OVF ||
      status_ff == obsd_pkg::STATUS_SHARE_OVF)
      else $error("illegal status code");

   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      status_ff != obsd_pkg::STATUS_OK && !(accept && req_tuser == obsd_pkg::KIND_BEGIN)
      |=> $stable(status_ff))
      else $error("held status changed");

endmodule

>>> sim/order_book_state_digest_tb.sv
`timescale 1ns / 1ps

module order_book_state_digest_tb;

   localparam logic [63:0] HASH_BASIS   = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] HASH_PRIME   = 64'h0000_0100_0000_01B3;
   localparam logic [55:0] HEADER_TAG   = 56'h41_45_47_49_53_42_4B;
   localparam logic [7:0]  HEADER_VER   = 8'h01;
   localparam int          RANDOM_ITEMS = 1650;
   localparam int          MAX_REPORTS  = 50;

   typedef struct {
      logic [obsd_pkg::KIND_W-1:0] kind;
      logic [63:0]       wide;
      logic [31:0]       word_a;
      logic [31:0]       word_b;
      logic [15:0]       locate;
      logic [7:0]        bytev;
      logic              at;
   } record_type;

   class book_digest_predictor;
      logic [63:0]           hash;
      logic [63:0]           seq_no;
      logic [31:0]           symbols;
      logic [63:0]           orders;
      logic [63:0]           bids;
      logic [63:0]           asks;
      logic [63:0]           shares;
      logic [obsd_pkg::STATUS_W-1:0]   status;
      logic [obsd_pkg::RSP_DATA_W-1:0] pending_digests [$];
      int                    mismatches;

      function new();
         clear();
         mismatches = 0;
      endfunction

      function void clear();
         hash    = HASH_BASIS;
         seq_no  = '0;
         symbols = '0;
         orders  = '0;
         bids    = '0;
         asks    = '0;
         shares  = '0;
         status  = obsd_pkg::STATUS_OK;
      endfunction

      function void mix(logic [7:0] b);
         hash = (hash ^ {56'd0, b}) * HASH_PRIME;
      endfunction

      // fold the low n bytes, most significant first
      function void mix_be(logic [63:0] v, int n);
         for (int i = n - 1; i >= 0; i--) mix(v[8*i +: 8]);
      endfunction

      function logic [63:0] sat_sum(logic [63:0] total, logic [63:0] v,
                                    logic [obsd_pkg::STATUS_W-1:0] code);
         logic [64:0] s;
         s = {1'b0, total} + {1'b0, v};
         if (s[64]) begin
            if (status == obsd_pkg::STATUS_OK) status = code;
            return '1;
         end
         return s[63:0];
      endfunction

      function void take_record(record_type r);
         logic [obsd_pkg::RSP_DATA_W-1:0] d;
         case (r.kind)
            obsd_pkg::KIND_BEGIN: begin
               clear();
               seq_no  = r.wide;
               symbols = r.word_a;
               mix_be({8'd0, HEADER_TAG}, 7);
               mix(HEADER_VER);
               mix_be(r.wide, 8);
               mix_be({32'd0, r.word_a}, 4);
            end
            obsd_pkg::KIND_BYTE: mix(r.bytev);
            obsd_pkg::KIND_LOCATE: mix_be({48'd0, r.locate}, 2);
            obsd_pkg::KIND_BID_COUNT: begin
               mix_be({32'd0, r.word_a}, 4);
               bids = sat_sum(bids, {32'd0, r.word_a}, obsd_pkg::STATUS_COUNT_OVF);
            end
            obsd_pkg::KIND_ASK_COUNT: begin
               mix_be({32'd0, r.word_a}, 4);
               asks = sat_sum(asks, {32'd0, r.word_a}, obsd_pkg::STATUS_COUNT_OVF);
            end
            obsd_pkg::KIND_LEVEL: begin
               mix_be({32'd0, r.word_a}, 4);
               mix_be(r.wide, 8);
               mix_be({32'd0, r.word_b}, 4);
               shares = sat_sum(shares, r.wide, obsd_pkg::STATUS_SHARE_OVF);
            end
            obsd_pkg::KIND_ORD_COUNT: begin
               mix_be(r.wide, 8);
               orders = sat_sum(orders, r.wide, obsd_pkg::STATUS_COUNT_OVF);
            end
            obsd_pkg::KIND_ORDER: begin
               mix_be(r.wide, 8);
               mix_be({48'd0, r.locate}, 2);
               mix(r.bytev);
               mix_be({32'd0, r.word_a}, 4);
               mix_be({32'd0, r.word_b}, 4);
               mix({7'd0, r.at});
            end
            obsd_pkg::KIND_FINISH: begin
               d = '0;
               d[417:0] = {status, shares, asks, bids, orders, symbols, seq_no, hash};
               pending_digests.insert(pending_digests.size(), d);
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         if (mismatches < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task cmp(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_digest(logic [obsd_pkg::RSP_DATA_W-1:0] got);
         logic [obsd_pkg::RSP_DATA_W-1:0] want;
         if (pending_digests.size() == 0) begin
            report($sformatf("digest %h with none pending", got[63:0]));
            return;
         end
         want = pending_digests.pop_front();
         cmp("digest_hash", got[63:0], want[63:0]);
         cmp("last_sequence", got[127:64], want[127:64]);
         cmp("symbols", {32'd0, got[159:128]}, {32'd0, want[159:128]});
         cmp("active_orders", got[223:160], want[223:160]);
         cmp("bid_levels", got[287:224], want[287:224]);
         cmp("ask_levels", got[351:288], want[351:288]);
         cmp("displayed_shares", got[415:352], want[415:352]);
         cmp("status", {62'd0, got[417:416]}, {62'd0, want[417:416]});
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [obsd_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [obsd_pkg::KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [obsd_pkg::RSP_DATA_W-1:0] rsp_tdata;

   book_digest_predictor book = new();
   int sent = 0;
   bit calm = 1'b0;
   int gap_odds = 0;
   int stall_left = 0;
   int stall_odds = 0;
   int odds_left = 0;

   order_book_state_digest dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL order_book_state_digest");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_digest(rsp_tdata);
      if (odds_left == 0) begin
         odds_left = $urandom_range(20, 200);
         stall_odds = $urandom_range(0, 3);
      end else begin
         odds_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, 10) <= stall_odds) begin
         stall_left = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic record_type rec(logic [obsd_pkg::KIND_W-1:0] kind, logic [63:0] wide,
                                      logic [31:0] wa, logic [31:0] wb, logic [15:0] sv,
                                      logic [7:0] bv, logic at);
      record_type r;
      r.kind   = kind;
      r.wide   = wide;
      r.word_a = wa;
      r.word_b = wb;
      r.locate = sv;
      r.bytev  = bv;
      r.at     = at;
      return r;
   endfunction

   function automatic record_type rand_rec(logic [obsd_pkg::KIND_W-1:0] kind);
      return rec(kind, {$urandom, $urandom}, $urandom, $urandom,
                 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
   endfunction

   // mostly small, now and then large enough to saturate a sum
   function automatic logic [63:0] amount(logic [63:0] typical);
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      return typical;
   endfunction

   task automatic send(record_type r);
      if (!calm && gap_odds != 0 && $urandom_range(1, 10) <= gap_odds) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {7'd0, r.at, r.bytev, r.locate, r.word_b, r.word_a, r.wide};
      do @(posedge clock); while (!req_tready);
      book.take_record(r);
      if (r.kind <= obsd_pkg::KIND_FINISH) sent++;
   endtask

   // hold off the sender until every digest is back
   task automatic drain();
      if (book.pending_digests.size() != 0) begin
         req_tvalid <= 1'b0;
         while (book.pending_digests.size() != 0) @(posedge clock);
      end
   endtask

   task automatic send_snapshot(bit broken);
      record_type r;
      int      nlev;
      int      nord;
      int      len;
      gap_odds = $urandom_range(0, 3);
      if (!broken || $urandom_range(0, 1) == 1) begin
         r = rand_rec(obsd_pkg::KIND_BEGIN);
         if ($urandom_range(0, 3) != 0) r.word_a = $urandom_range(1, 9000);
         send(r);
      end
      repeat ($urandom_range(1, 3)) begin
         len = $urandom_range(1, 4);
         r = rand_rec(obsd_pkg::KIND_BYTE);
         r.bytev = 8'(len);
         send(r);
         repeat (len) begin
            r = rand_rec(obsd_pkg::KIND_BYTE);
            r.bytev = 8'($urandom_range(8'h41, 8'h5A));
            send(r);
         end
         send(rand_rec(obsd_pkg::KIND_LOCATE));
         for (int s = 0; s < 2; s++) begin
            nlev = $urandom_range(0, 3);
            r = rand_rec(s == 0 ? obsd_pkg::KIND_BID_COUNT : obsd_pkg::KIND_ASK_COUNT);
            if ($urandom_range(0, 7) != 0) r.word_a = 32'(nlev);
            send(r);
            repeat (nlev) begin
               r = rand_rec(obsd_pkg::KIND_LEVEL);
               r.wide = amount(64'($urandom_range(1, 50000)));
               send(r);
            end
         end
         nord = $urandom_range(0, 3);
         r = rand_rec(obsd_pkg::KIND_ORD_COUNT);
         r.wide = amount(64'(nord));
         send(r);
         repeat (nord) begin
            r = rand_rec(obsd_pkg::KIND_ORDER);
            r.bytev = $urandom_range(0, 1) ? 8'h42 : 8'h53;
            send(r);
            if (r.at) begin
               repeat (4) begin
                  r = rand_rec(obsd_pkg::KIND_BYTE);
                  r.bytev = 8'($urandom_range(8'h41, 8'h5A));
                  send(r);
               end
            end
         end
         if (broken && $urandom_range(0, 3) == 0) send(rand_rec(obsd_pkg::KIND_FINISH));
      end
      if (!broken || $urandom_range(0, 1) == 1) send(rand_rec(obsd_pkg::KIND_FINISH));
   endtask

   task automatic send_noise();
      gap_odds = $urandom_range(0, 3);
      repeat ($urandom_range(1, 6)) send(rand_rec(4'($urandom_range(0, 15))));
   endtask

   initial begin
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // records ahead of any begin fold into the reset state
      send(rec(obsd_pkg::KIND_BYTE, '1, '1, '1, '1, 8'h00, 1'b1));
      send(rec(obsd_pkg::KIND_LOCATE, '0, '0, '0, 16'hFFFF, '0, 1'b0));
      send(rec(obsd_pkg::KIND_FINISH, '0, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_BEGIN, '1, '1, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_BYTE, '0, '0, '0, '0, 8'hFF, 1'b0));
      send(rec(obsd_pkg::KIND_LOCATE, '1, '1, '1, 16'h0000, '1, 1'b1));
      send(rec(obsd_pkg::KIND_BID_COUNT, '0, '1, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_ASK_COUNT, '1, '0, '1, '1, '1, 1'b1));
      send(rec(obsd_pkg::KIND_LEVEL, '0, '1, '1, '0, '0, 1'b0));
      // sum lands exactly on all ones without overflow
      send(rec(obsd_pkg::KIND_ORD_COUNT, '1, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_ORDER, '1, '1, '0, 16'hFFFF, 8'hFF, 1'b1));
      send(rec(obsd_pkg::KIND_ORDER, '0, '0, '1, 16'h0000, 8'h00, 1'b0));
      for (int k = 9; k < 16; k++) send(rand_rec(4'(k)));
      send(rec(obsd_pkg::KIND_FINISH, '1, '1, '1, '1, '1, 1'b1));
      send(rec(obsd_pkg::KIND_FINISH, '0, '0, '0, '0, '0, 1'b0));
      // count overflow first; the later level sum lands on all ones without a share overflow
      send(rec(obsd_pkg::KIND_ORD_COUNT, 64'd1, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_LEVEL, '1, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_FINISH, '0, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_BEGIN, '0, '0, '1, '1, '1, 1'b1));
      send(rec(obsd_pkg::KIND_LEVEL, '1, 32'd7, 32'd3, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_LEVEL, 64'd1, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_ORD_COUNT, '1, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_ORD_COUNT, 64'd5, '0, '0, '0, '0, 1'b0));
      send(rec(obsd_pkg::KIND_FINISH, '0, '0, '0, '0, '0, 1'b0));
      send(rand_rec(obsd_pkg::KIND_BEGIN));
      send(rand_rec(obsd_pkg::KIND_FINISH));
      drain();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = sent >= RANDOM_ITEMS - 200;
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_snapshot(1'b0);
         end else if (pick < 17) begin
            send_noise();
         end else begin
            send_snapshot(1'b1);
         end
         if (pick == 0 && !calm) drain();
      end
      req_tvalid <= 1'b0;

      while (book.pending_digests.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (book.mismatches == 0) begin
         $display("PASS order_book_state_digest");
      end else begin
         $display("FAIL order_book_state_digest");
      end
      $finish;
   end

endmodule
